// ===== rtl/pbfp_pkg.sv =====
// Shared types, widths and codes of the plane buffer flush policy unit.
package pbfp_pkg;

  localparam int NUM_PLANES = 16;
  localparam int PLANE_W    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int IDX_W      = $clog2(NUM_PLANES + 1);
  localparam int NUSE_W     = $clog2(NUM_PLANES + 1);

  localparam int PID_W      = 8;
  localparam int KIND_W     = 2;
  localparam int PIDX_W     = 6;
  localparam int CNT_W      = 25;
  localparam int CHUNK_W    = 20;
  localparam int MAXT_W     = 24;
  localparam int MIM_W      = 6;
  localparam int TOTAL_W    = CNT_W + PLANE_W;
  localparam int ENTRY_W    = 2 * CNT_W;

  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = APB_AW - 2;

  localparam logic [CNT_W-1:0]   CNT_MAX         = {CNT_W{1'b1}};
  localparam logic [CHUNK_W-1:0] CHUNK_RST       = CHUNK_W'(1024);
  localparam logic [MAXT_W-1:0]  MAX_TOTAL_RST   = MAXT_W'(65536);
  localparam logic [MIM_W-1:0]   MAX_IN_MEM_RST  = MIM_W'(10);

  localparam logic [REG_IDX_W-1:0] REG_GROW_STEP  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_MAX_TOTAL  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_MAX_IN_MEM = REG_IDX_W'(2);

  typedef enum logic [KIND_W-1:0] {
    KIND_FLUSH   = 2'd0,
    KIND_STORED  = 2'd1,
    KIND_DROPPED = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CHUNK_W-1:0] grow_step;
    logic [MAXT_W-1:0]  max_total;
    logic [MIM_W-1:0]   max_in_mem;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] alloc;
    logic [CNT_W-1:0] used;
  } entry_t;

endpackage

// ===== rtl/pbfp_chan_if.sv =====
// Valid/ready channel interfaces for arriving items and results.
interface pbfp_in_if;
  logic                       valid;
  logic                       ready;
  logic [pbfp_pkg::PID_W-1:0] plane_id;

  modport source (output valid, output plane_id, input ready);
  modport sink   (input valid, input plane_id, output ready);
endinterface

interface pbfp_res_if;
  logic                        valid;
  logic                        ready;
  logic [pbfp_pkg::KIND_W-1:0] result_kind;
  logic [pbfp_pkg::PIDX_W-1:0] plane_index;
  logic [pbfp_pkg::CNT_W-1:0]  flushed_count;
  logic                        last;

  modport source (output valid, output result_kind, output plane_index,
                  output flushed_count, output last, input ready);
  modport sink   (input valid, input result_kind, input plane_index,
                  input flushed_count, input last, output ready);
endinterface

// ===== rtl/plane_buffer_flush_policy_unit.sv =====
// Plane buffer flush policy unit: top level with register file and sequencer.
// Each accepted item passes a scan of all planes, a decision, a flush pass if a rule fires
// and then a store or drop; a flush beat or the final beat can stall on the output. No new
// item is taken until its final beat is loaded. The scan reads one plane per cycle through
// the single RAM read port; the flush pass reads and then evaluates each plane in turn.
// Reset: configuration takes its reset values and the per-plane valid bits clear at once,
// so every plane reads as empty straight after reset; no clearing pass is needed.
module plane_buffer_flush_policy_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pbfp_pkg::APB_AW-1:0] paddr,
  input  logic [pbfp_pkg::APB_DW-1:0] pwdata,
  output logic [pbfp_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  pbfp_in_if.sink                     in_i,
  pbfp_res_if.source                  res_o
);
  import pbfp_pkg::*;

  cfg_t cfg;

  // Configuration: the user must write it only while the sequencer is idle; not enforced here.
  pbfp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: per item, scan all planes to sum allocations and count planes in use,
  // decide on the flush rules, sweep the planes again to flush in ascending order if a rule
  // fires, then read-modify-write the target plane or drop an item out of range. Results
  // leave through an output register, so the next item is taken while the final beat waits.
  pbfp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .res_o  (res_o)
  );

endmodule

// ===== rtl/pbfp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module pbfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pbfp_regs.sv =====
// APB-style configuration register file.
module pbfp_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbfp_pkg::APB_AW-1:0]   paddr,
  input  logic [pbfp_pkg::APB_DW-1:0]   pwdata,
  output logic [pbfp_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output pbfp_pkg::cfg_t                cfg_o
);
  import pbfp_pkg::*;

  cfg_t                 cfg_q;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grow_step  <= CHUNK_RST;
      cfg_q.max_total  <= MAX_TOTAL_RST;
      cfg_q.max_in_mem <= MAX_IN_MEM_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_GROW_STEP:  cfg_q.grow_step  <= pwdata[CHUNK_W-1:0];
        REG_MAX_TOTAL:  cfg_q.max_total  <= pwdata[MAXT_W-1:0];
        REG_MAX_IN_MEM: cfg_q.max_in_mem <= pwdata[MIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GROW_STEP:  prdata = APB_DW'(cfg_q.grow_step);
      REG_MAX_TOTAL:  prdata = APB_DW'(cfg_q.max_total);
      REG_MAX_IN_MEM: prdata = APB_DW'(cfg_q.max_in_mem);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pbfp_ctrl.sv =====
// Sequencer: scans the plane table in RAM, flushes if a rule fires, then stores or drops the item.
module pbfp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pbfp_pkg::cfg_t cfg_i,
  pbfp_in_if.sink        in_i,
  pbfp_res_if.source     res_o
);
  import pbfp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_FRD, S_FEV, S_SRD, S_SEV
  } state_e;

  state_e               state_q;
  logic [PID_W-1:0]     pid_q;
  logic [IDX_W-1:0]     cnt_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [NUSE_W-1:0]    inuse_q;
  logic [CNT_W-1:0]     best_q;
  logic [PLANE_W-1:0]   best_idx_q;
  logic                 flush_all_q;
  logic                 best_en_q;
  logic [NUM_PLANES-1:0] valid_q;
  logic                 rd_vld_q;

  logic                 out_valid_q;
  kind_e                out_kind_q;
  logic [PIDX_W-1:0]    out_idx_q;
  logic [CNT_W-1:0]     out_cnt_q;
  logic                 out_last_q;

  logic                 ram_re, ram_we;
  logic [PLANE_W-1:0]   ram_raddr, ram_waddr;
  entry_t               ram_wdata, ram_rdata, rd_entry;

  logic                 out_free, pid_ok, flush_hit, entry_used, out_load;
  logic                 do_flush_all, do_best;
  logic [IDX_W-1:0]     scan_idx;
  logic [CNT_W:0]       grow_sum, used_sum;
  logic [CNT_W-1:0]     new_alloc, new_used;

  pbfp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_PLANES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // An entry never written since reset reads as zero.
  assign rd_entry   = rd_vld_q ? ram_rdata : '0;
  assign entry_used = (rd_entry.used != '0);
  assign out_free   = !out_valid_q || res_o.ready;
  assign pid_ok     = (pid_q < PID_W'(NUM_PLANES));
  assign scan_idx   = cnt_q - IDX_W'(1);
  assign flush_hit  = (flush_all_q || (best_en_q && (cnt_q[PLANE_W-1:0] == best_idx_q)))
                      && entry_used;
  // Load the output register with a flush beat or with the final beat.
  assign out_load   = ((state_q == S_FEV) && flush_hit && out_free)
                      || ((state_q == S_SEV) && out_free);

  assign do_flush_all = (7'(inuse_q) > 7'(cfg_i.max_in_mem));
  assign do_best      = (total_q >= TOTAL_W'(cfg_i.max_total)) && (inuse_q != '0);

  assign grow_sum = {1'b0, rd_entry.alloc} + (CNT_W+1)'(cfg_i.grow_step);
  assign used_sum = {1'b0, rd_entry.used} + (CNT_W+1)'(1);

  always_comb begin
    if (rd_entry.alloc == '0) begin
      new_alloc = CNT_W'(cfg_i.grow_step);
    end else if (rd_entry.used >= rd_entry.alloc) begin
      new_alloc = grow_sum[CNT_W] ? CNT_MAX : grow_sum[CNT_W-1:0];
    end else begin
      new_alloc = rd_entry.alloc;
    end
    new_used = used_sum[CNT_W] ? CNT_MAX : used_sum[CNT_W-1:0];
  end

  // RAM port control: at most one read or one write per cycle, never both.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cnt_q[PLANE_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = cnt_q[PLANE_W-1:0];
    ram_wdata = '0;
    case (state_q)
      S_IDLE: begin
        ram_re    = in_i.valid;
        ram_raddr = '0;
      end
      S_SCAN: begin
        ram_re = (cnt_q < IDX_W'(NUM_PLANES));
      end
      S_FRD: begin
        ram_re = 1'b1;
      end
      S_FEV: begin
        ram_we = flush_hit && out_free;
      end
      S_SRD: begin
        ram_re    = pid_ok;
        ram_raddr = pid_q[PLANE_W-1:0];
      end
      S_SEV: begin
        ram_we    = pid_ok && out_free;
        ram_waddr = pid_q[PLANE_W-1:0];
        ram_wdata = '{alloc: new_alloc, used: new_used};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pid_q       <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      inuse_q     <= '0;
      best_q      <= '0;
      best_idx_q  <= '0;
      flush_all_q <= 1'b0;
      best_en_q   <= 1'b0;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_DROPPED;
      out_idx_q   <= '0;
      out_cnt_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ram_re) begin
        rd_vld_q <= valid_q[ram_raddr];
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            pid_q   <= in_i.plane_id;
            cnt_q   <= IDX_W'(1);
            total_q <= '0;
            inuse_q <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          total_q <= total_q + TOTAL_W'(rd_entry.alloc);
          inuse_q <= inuse_q + NUSE_W'(entry_used);
          // Plane 0 seeds the search whether in use or not.
          if (cnt_q == IDX_W'(1)) begin
            best_q     <= rd_entry.alloc;
            best_idx_q <= '0;
          end else if ((rd_entry.alloc > best_q) && entry_used) begin
            best_q     <= rd_entry.alloc;
            best_idx_q <= scan_idx[PLANE_W-1:0];
          end
          if (cnt_q == IDX_W'(NUM_PLANES)) begin
            state_q <= S_DECIDE;
          end else begin
            cnt_q <= cnt_q + IDX_W'(1);
          end
        end
        S_DECIDE: begin
          flush_all_q <= do_flush_all;
          best_en_q   <= do_best;
          cnt_q       <= '0;
          state_q     <= (do_flush_all || do_best) ? S_FRD : S_SRD;
        end
        S_FRD: begin
          state_q <= S_FEV;
        end
        S_FEV: begin
          // Hold on a hit until the output register frees up.
          if (!flush_hit || out_free) begin
            if (flush_hit) begin
              out_kind_q  <= KIND_FLUSH;
              out_idx_q   <= PIDX_W'(cnt_q[PLANE_W-1:0]);
              out_cnt_q   <= rd_entry.used;
              out_last_q  <= 1'b0;
            end
            if (cnt_q == IDX_W'(NUM_PLANES - 1)) begin
              state_q <= S_SRD;
            end else begin
              cnt_q   <= cnt_q + IDX_W'(1);
              state_q <= S_FRD;
            end
          end
        end
        S_SRD: begin
          state_q <= S_SEV;
        end
        S_SEV: begin
          if (out_free) begin
            out_kind_q  <= pid_ok ? KIND_STORED : KIND_DROPPED;
            out_idx_q   <= pid_ok ? PIDX_W'(pid_q[PLANE_W-1:0]) : '0;
            out_cnt_q   <= '0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign res_o.valid         = out_valid_q;
  assign res_o.result_kind   = out_kind_q;
  assign res_o.plane_index   = out_idx_q;
  assign res_o.flushed_count = out_cnt_q;
  assign res_o.last          = out_last_q;

  // The sequence never reads and writes one entry in the same cycle.
  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_re && ram_we && (ram_raddr == ram_waddr)))
    else $error("RAM read and write hit the same entry");

  // A flush is only reported for a plane in use.
  a_flush_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KIND_FLUSH)) |-> (out_cnt_q != '0))
    else $error("flush reported with zero used count");

  // Last marks the store or drop result and nothing else.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_kind_q != KIND_FLUSH)))
    else $error("last does not match result kind");

  // A new result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> out_valid_q && $stable(out_kind_q)
                                       && $stable(out_idx_q) && $stable(out_cnt_q))
    else $error("pending result overwritten");

endmodule
